// ===== hdl/text_console_cursor_scroll_defines.svh =====
// ----------------------------------------------------------------------------
// text console assertion macros
// shared concurrent check forms for the console engine
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tcc check failed");

// next-cycle implication, disabled during reset
`define TCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tcc check failed");

`endif

// ===== hdl/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// geometry, field types and codes of the text console engine
// ----------------------------------------------------------------------------
package tcc_pkg;

    // screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int LINE_W     = $clog2(ROWS);
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    // scroll sweep bounds
    localparam int LAST_BASE  = (ROWS - 1) * COLUMNS;
    localparam int COPY_LAST  = LAST_BASE - 1;
    localparam int CELL_LAST  = CELL_COUNT - 1;

    // request queue
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // field types
    typedef logic [0:0]  t_cmd;
    typedef logic [7:0]  t_char;
    typedef logic [7:0]  t_attr;
    typedef logic [10:0] t_cell_addr;
    typedef logic [15:0] t_cell;
    typedef logic [10:0] t_cur_index;
    typedef logic [4:0]  t_cur_line;
    typedef logic [6:0]  t_cur_col;

    // codes
    localparam t_cmd  CMD_PUT      = 1'b0;
    localparam t_cmd  CMD_READ     = 1'b1;
    localparam t_char NEWLINE_CODE = 8'h0A;
    localparam t_cell BLANK_CELL   = 16'h0720;
    localparam t_attr RESET_COLOUR = 8'h07;

    // classified request
    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_NEWLINE = 2'd1,
        OP_CHAR    = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        t_char      char_code;
        t_cell_addr cell_address;
    } t_task;

endpackage

// ===== hdl/tcc_req_if.sv =====
// ----------------------------------------------------------------------------
// tcc_req_if
// request channel: command, character and cell address
// ----------------------------------------------------------------------------
interface tcc_req_if;
    import tcc_pkg::*;

    logic       valid;
    logic       ready;
    t_cmd       command;
    t_char      char_code;
    t_cell_addr cell_address;

    modport source (output valid, output command, output char_code, output cell_address,
                    input ready);
    modport sink   (input valid, input command, input char_code, input cell_address,
                    output ready);
endinterface

// ===== hdl/tcc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tcc_rsp_if
// result channel: cell data, cursor position and scroll flag
// ----------------------------------------------------------------------------
interface tcc_rsp_if;
    import tcc_pkg::*;

    logic       valid;
    logic       ready;
    t_cell      read_data;
    t_cur_index cursor_index;
    t_cur_line  cursor_line;
    t_cur_col   cursor_column;
    logic       scrolled;

    modport source (output valid, output read_data, output cursor_index, output cursor_line,
                    output cursor_column, output scrolled, input ready);
    modport sink   (input valid, input read_data, input cursor_index, input cursor_line,
                    input cursor_column, input scrolled, output ready);
endinterface

// ===== hdl/tcc_front.sv =====
// ----------------------------------------------------------------------------
// tcc_front
// accepts requests and sorts them into read, newline and character
// ----------------------------------------------------------------------------
module tcc_front (
    tcc_req_if.sink        i_req,
    input  logic           i_q_full,
    output logic           o_push,
    output tcc_pkg::t_task o_task
);
    import tcc_pkg::*;

    // accept whenever the queue has room
    assign i_req.ready = !i_q_full;
    assign o_push      = i_req.valid && !i_q_full;

    // classify the request
    always_comb begin
        if (i_req.command == CMD_READ) begin
            o_task.op = OP_READ;
        end else if (i_req.char_code == NEWLINE_CODE) begin
            o_task.op = OP_NEWLINE;
        end else begin
            o_task.op = OP_CHAR;
        end
        o_task.char_code    = i_req.char_code;
        o_task.cell_address = i_req.cell_address;
    end
endmodule

// ===== hdl/tcc_queue.sv =====
// ----------------------------------------------------------------------------
// tcc_queue
// short fifo of classified requests between front and engine
// ----------------------------------------------------------------------------
module tcc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tcc_pkg::t_task i_task,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output tcc_pkg::t_task o_task
);
    import tcc_pkg::*;

    t_task              r_slot [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_PTR_W-1:0] n_wr_ptr;
    logic [Q_PTR_W-1:0] n_rd_ptr;
    logic [Q_CNT_W-1:0] n_count;

    assign o_full  = (r_count == Q_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_task  = r_slot[r_rd_ptr];

    // pointer and fill level update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // payload slots
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_task;
        end
    end
endmodule

// ===== hdl/tcc_back.sv =====
// ----------------------------------------------------------------------------
// tcc_back
// console engine: screen store, cursor, scroll sweep and result register
// ----------------------------------------------------------------------------
module tcc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tcc_pkg::t_attr i_text_color,
    input  logic           i_q_valid,
    input  tcc_pkg::t_task i_task,
    output logic           o_pop,
    tcc_rsp_if.source      o_rsp
);
    import tcc_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_COPY  = 5'b01000,
        ST_FILL  = 5'b10000
    } t_back_state;

    // screen store
    t_cell              r_screen [CELL_COUNT];
    t_cell              r_rdata;

    t_back_state        r_state, n_state;
    logic [ADDR_W-1:0]  r_cnt, n_cnt;
    logic [ADDR_W-1:0]  r_dst, n_dst;
    logic               r_pend, n_pend;
    logic [LINE_W-1:0]  r_line, n_line;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ADDR_W-1:0]  r_pos, n_pos;
    logic [ADDR_W-1:0]  r_base, n_base;

    logic               r_out_valid;
    t_cell              r_out_data;
    t_cur_index         r_out_index;
    t_cur_line          r_out_line;
    t_cur_col           r_out_col;
    logic               r_out_scrolled;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    t_cell              mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic               load;
    t_cell              ld_data;
    logic               slot_free;
    logic               in_range;
    logic [31:0]        wide_addr;
    logic [31:0]        wide_pos;
    logic [31:0]        wide_line;
    logic [31:0]        wide_col;

    assign slot_free = !r_out_valid || o_rsp.ready;
    assign wide_addr = 32'(i_task.cell_address);
    assign in_range  = (wide_addr < 32'(CELL_COUNT));

    // sequencing of requests, scroll sweep and clearing pass
    always_comb begin
        logic do_break;
        do_break  = 1'b0;
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_dst     = r_dst;
        n_pend    = 1'b0;
        n_line    = r_line;
        n_col     = r_col;
        n_pos     = r_pos;
        n_base    = r_base;
        mem_we    = 1'b0;
        mem_waddr = r_dst;
        mem_wdata = r_rdata;
        mem_re    = 1'b0;
        mem_raddr = wide_addr[ADDR_W-1:0];
        o_pop     = 1'b0;
        load      = 1'b0;
        ld_data   = '0;

        // copy write lands in the cycle after its read
        if (r_pend) begin
            mem_we = 1'b1;
        end

        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = BLANK_CELL;
                if (r_cnt == ADDR_W'(CELL_LAST)) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_q_valid && slot_free) begin
                    o_pop = 1'b1;
                    case (i_task.op)
                        OP_READ: begin
                            if (in_range) begin
                                mem_re  = 1'b1;
                                n_state = ST_READ;
                            end else begin
                                load = 1'b1;
                            end
                        end
                        OP_NEWLINE: begin
                            do_break = 1'b1;
                        end
                        OP_CHAR: begin
                            mem_we    = 1'b1;
                            mem_waddr = r_pos;
                            mem_wdata = {i_text_color, i_task.char_code};
                            if (r_col == COL_W'(COLUMNS - 1)) begin
                                do_break = 1'b1;
                            end else begin
                                n_col = r_col + 1'b1;
                                n_pos = r_pos + 1'b1;
                                load  = 1'b1;
                            end
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                load    = 1'b1;
                ld_data = r_rdata;
                n_state = ST_IDLE;
            end
            ST_COPY: begin
                mem_re    = 1'b1;
                mem_raddr = r_cnt + ADDR_W'(COLUMNS);
                n_pend    = 1'b1;
                n_dst     = r_cnt;
                if (r_cnt == ADDR_W'(COPY_LAST)) begin
                    n_cnt   = ADDR_W'(LAST_BASE);
                    n_state = ST_FILL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_FILL: begin
                if (!r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cnt;
                    mem_wdata = BLANK_CELL;
                    if (r_cnt == ADDR_W'(CELL_LAST)) begin
                        n_cnt   = '0;
                        load    = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // line break, scrolling from the last row
        if (do_break) begin
            n_col = '0;
            if (r_line == LINE_W'(ROWS - 1)) begin
                n_base  = ADDR_W'(LAST_BASE);
                n_pos   = ADDR_W'(LAST_BASE);
                n_cnt   = '0;
                n_state = ST_COPY;
            end else begin
                n_line = r_line + 1'b1;
                n_base = r_base + ADDR_W'(COLUMNS);
                n_pos  = r_base + ADDR_W'(COLUMNS);
                load   = 1'b1;
            end
        end
    end

    assign wide_pos  = 32'(n_pos);
    assign wide_line = 32'(n_line);
    assign wide_col  = 32'(n_col);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_line      <= '0;
            r_col       <= '0;
            r_pos       <= '0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            r_line  <= n_line;
            r_col   <= n_col;
            r_pos   <= n_pos;
            r_base  <= n_base;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload and copy destination
    always_ff @(posedge i_clk) begin
        r_dst <= n_dst;
        if (load) begin
            r_out_data     <= ld_data;
            r_out_index    <= wide_pos[10:0];
            r_out_line     <= wide_line[4:0];
            r_out_col      <= wide_col[6:0];
            r_out_scrolled <= (r_state == ST_FILL);
        end
    end

    // store write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_screen[mem_waddr] <= mem_wdata;
        end
    end

    // store read port
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_screen[mem_raddr];
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.read_data     = r_out_data;
    assign o_rsp.cursor_index  = r_out_index;
    assign o_rsp.cursor_line   = r_out_line;
    assign o_rsp.cursor_column = r_out_col;
    assign o_rsp.scrolled      = r_out_scrolled;
endmodule

// ===== hdl/text_console_cursor_scroll.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// text-mode console engine with cursor tracking and scroll-up
// ----------------------------------------------------------------------------
// After reset the engine sweeps the 80 x 25 screen store to blank cells, one
// cell a cycle; requests are queued but not served until it finishes, while
// colour writes are taken at any time. A read goes through the store's
// registered read port. A break from the last row scrolls: the engine copies
// (ROWS-1) x COLUMNS cells through the store's one read port and one write
// port and blanks the bottom row. A two-entry request queue lets new requests
// be accepted while the engine is busy or a result is waiting in the output
// register.
`include "text_console_cursor_scroll_defines.svh"

module text_console_cursor_scroll (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  tcc_pkg::t_attr i_cfg_wdata,
    tcc_req_if.sink        i_req,
    tcc_rsp_if.source      o_rsp
);
    import tcc_pkg::*;

    t_attr r_text_color;
    logic  q_full;
    logic  q_push;
    logic  q_valid;
    logic  q_pop;
    t_task front_task;
    t_task queue_task;

    // colour register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= RESET_COLOUR;
        end else if (i_cfg_we) begin
            r_text_color <= i_cfg_wdata;
        end
    end

    // request intake
    tcc_front u_front (
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_task   (front_task)
    );

    // request queue
    tcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_task  (front_task),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_task  (queue_task)
    );

    // console engine
    tcc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text_color (r_text_color),
        .i_q_valid    (q_valid),
        .i_task       (queue_task),
        .o_pop        (q_pop),
        .o_rsp        (o_rsp)
    );

    // checks
    `TCC_ASSERT_NOW(a_pop_needs_entry, i_clk, i_rst_n, q_pop, q_valid)
    `TCC_ASSERT_NOW(a_scroll_at_col0, i_clk, i_rst_n, o_rsp.valid && o_rsp.scrolled, o_rsp.cursor_column == '0)
    `TCC_ASSERT_NOW(a_read_no_scroll, i_clk, i_rst_n, o_rsp.valid && (o_rsp.read_data != '0), !o_rsp.scrolled)
    `TCC_ASSERT_NEXT(a_full_blocks, i_clk, i_rst_n, q_full && !q_pop, !i_req.ready)
endmodule

// ===== tb/sv/tcc_console_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_console_checker
// Watches the request, result and colour ports of the console engine. Keeps
// its own screen store, cursor and colour, works out the result of every
// accepted request and compares each accepted result with the oldest one.
// ----------------------------------------------------------------------------
module tcc_console_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  tcc_pkg::t_attr i_cfg_wdata,
    tcc_req_if             i_req,
    tcc_rsp_if             i_rsp,
    output int             o_fail_count,
    output int             o_pending
);
    import tcc_pkg::*;

    // keep the log short when the engine is badly off
    localparam int PRINT_LIMIT = 60;

    typedef struct packed {
        t_cell      read_data;
        t_cur_index cursor_index;
        t_cur_line  cursor_line;
        t_cur_col   cursor_column;
        logic       scrolled;
    } t_cursor_report;

    t_cell          screen_model [CELL_COUNT];
    int unsigned    cur_line;
    int unsigned    cur_col;
    t_attr          pen_colour;
    t_cursor_report expected_reports [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_error(input string msg);
        if (o_fail_count < PRINT_LIMIT) begin
            $display("[%0t] ERROR %s", $time, msg);
        end
        o_fail_count++;
    endtask

    // cursor to column 0 of the next row, scrolling from the last row
    function automatic logic break_line();
        if (cur_line + 1 >= ROWS) begin
            for (int i = 0; i < LAST_BASE; i++) begin
                screen_model[i] = screen_model[i + COLUMNS];
            end
            for (int i = LAST_BASE; i < CELL_COUNT; i++) begin
                screen_model[i] = BLANK_CELL;
            end
            cur_col = 0;
            return 1'b1;
        end
        cur_line++;
        cur_col = 0;
        return 1'b0;
    endfunction

    // apply one request to the screen and cursor, return the cursor report
    function automatic t_cursor_report console_step(t_cmd cmd, t_char ch, t_cell_addr addr);
        t_cursor_report rep;
        int unsigned    pos;
        rep = '0;
        if (cmd == CMD_READ) begin
            if (addr < CELL_COUNT) begin
                rep.read_data = screen_model[addr];
            end
        end else if (ch == NEWLINE_CODE) begin
            rep.scrolled = break_line();
        end else begin
            pos = cur_line * COLUMNS + cur_col;
            if (pos < CELL_COUNT) begin
                screen_model[pos] = {pen_colour, ch};
            end
            cur_col++;
            if (cur_col >= COLUMNS) begin
                rep.scrolled = break_line();
            end
        end
        pos = cur_line * COLUMNS + cur_col;
        rep.cursor_index  = t_cur_index'(pos);
        rep.cursor_line   = t_cur_line'(cur_line);
        rep.cursor_column = t_cur_col'(cur_col);
        return rep;
    endfunction

    // results are checked before the request of the same edge is queued
    always @(posedge i_clk) begin : monitor
        t_cursor_report want;
        if (!i_rst_n) begin
            for (int i = 0; i < CELL_COUNT; i++) begin
                screen_model[i] = BLANK_CELL;
            end
            cur_line   = 0;
            cur_col    = 0;
            pen_colour = RESET_COLOUR;
            expected_reports.delete();
        end else begin
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) begin
                if (expected_reports.size() == 0) begin
                    report_error("result with no request outstanding");
                end else begin
                    want = expected_reports.pop_front();
                    if (i_rsp.read_data !== want.read_data) begin
                        report_error($sformatf("read_data got %04h expected %04h",
                                               i_rsp.read_data, want.read_data));
                    end
                    if (i_rsp.cursor_index !== want.cursor_index) begin
                        report_error($sformatf("cursor_index got %0d expected %0d",
                                               i_rsp.cursor_index, want.cursor_index));
                    end
                    if (i_rsp.cursor_line !== want.cursor_line) begin
                        report_error($sformatf("cursor_line got %0d expected %0d",
                                               i_rsp.cursor_line, want.cursor_line));
                    end
                    if (i_rsp.cursor_column !== want.cursor_column) begin
                        report_error($sformatf("cursor_column got %0d expected %0d",
                                               i_rsp.cursor_column, want.cursor_column));
                    end
                    if (i_rsp.scrolled !== want.scrolled) begin
                        report_error($sformatf("scrolled got %b expected %b",
                                               i_rsp.scrolled, want.scrolled));
                    end
                end
            end
            if (i_cfg_we === 1'b1) begin
                pen_colour = i_cfg_wdata;
            end
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1) begin
                expected_reports.push_back(console_step(i_req.command, i_req.char_code,
                                                        i_req.cell_address));
            end
        end
        o_pending = expected_reports.size();
    end

endmodule

// ===== tb/sv/tb_text_console_cursor_scroll.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_cursor_scroll
// Drives the console engine with a short directed set (store edges, reads
// beyond the store, extreme characters, newline, colour changes) and then
// random phases of print runs, newline bursts, reads and noise, each phase
// under its own text colour. Requests come in random bursts, results are
// stalled on a pattern of their own; the checker beside the engine compares.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_scroll;
    import tcc_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 90;
    localparam int GAP_MAX       = 8;
    localparam int STALL_MAX     = 12;
    localparam int DRAIN_CYCLES  = 64;
    // up to about 900 requests, each scrolling, behind the longest gap and stall,
    // plus the clearing sweep after reset, with ample margin
    localparam int TIMEOUT_CYCLES = 10_000_000;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_LONG
    } t_stall_mode;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_cfg_we;
    t_attr i_cfg_wdata;
    int    fail_count;
    int    pending;
    int    burst_left;

    tcc_req_if req_ch ();
    tcc_rsp_if rsp_ch ();

    text_console_cursor_scroll DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    tcc_console_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // run limit
    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    // result stall pattern, with a new random mode after each random-length run
    initial begin : result_stall
        t_stall_mode mode;
        int          left;
        int          stall;
        rsp_ch.ready = 1'b0;
        mode         = STALL_NONE;
        left         = 0;
        stall        = 0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = t_stall_mode'($urandom_range(0, 3));
                left = $urandom_range(16, 96);
            end
            left--;
            case (mode)
                STALL_NONE: begin
                    rsp_ch.ready <= 1'b1;
                end
                STALL_RANDOM: begin
                    rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                end
                STALL_PERIODIC: begin
                    rsp_ch.ready <= (left % 3 == 0);
                end
                default: begin
                    if (stall > 0) begin
                        stall--;
                        rsp_ch.ready <= 1'b0;
                    end else begin
                        rsp_ch.ready <= 1'b1;
                        if ($urandom_range(0, 3) == 0) begin
                            stall = $urandom_range(4, STALL_MAX);
                        end
                    end
                end
            endcase
        end
    end

    // one request, sent in bursts with random gaps; returns at a falling edge
    // with valid still high so that the next request can follow at once
    task automatic send_request(input t_cmd cmd, input t_char ch, input t_cell_addr addr);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, GAP_MAX);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        req_ch.valid        <= 1'b1;
        req_ch.command      <= cmd;
        req_ch.char_code    <= ch;
        req_ch.cell_address <= addr;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    // stop requesting and let every outstanding request come back
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic set_colour(input t_attr colour);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= colour;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // stimulus and verdict
    initial begin : stimulus
        t_attr      phase_colour [RANDOM_PHASES];
        int         sent;
        int         pick;
        int         run_len;
        t_char      ch;
        t_cell_addr addr;

        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        req_ch.valid        = 1'b0;
        req_ch.command      = CMD_PUT;
        req_ch.char_code    = '0;
        req_ch.cell_address = '0;
        burst_left          = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // store edges and extreme characters under the reset colour
        send_request(CMD_READ, 8'h00, 11'd0);
        send_request(CMD_READ, 8'h00, 11'd1999);
        send_request(CMD_READ, 8'h00, 11'd2000);
        send_request(CMD_READ, 8'hFF, 11'd2047);
        send_request(CMD_PUT, 8'h00, 11'd0);
        send_request(CMD_PUT, 8'hFF, 11'd2047);
        send_request(CMD_READ, 8'h00, 11'd0);
        send_request(CMD_READ, 8'h00, 11'd1);
        send_request(CMD_PUT, NEWLINE_CODE, 11'd0);
        send_request(CMD_READ, 8'h00, 11'd80);

        // colour changes on the second row
        set_colour(8'hFF);
        send_request(CMD_PUT, 8'h41, 11'd0);
        send_request(CMD_READ, 8'h00, 11'd80);
        send_request(CMD_PUT, 8'h0E, 11'd0);
        set_colour(8'h00);
        send_request(CMD_PUT, 8'h0F, 11'd0);
        send_request(CMD_READ, 8'h00, 11'd82);
        send_request(CMD_PUT, NEWLINE_CODE, 11'd0);
        send_request(CMD_PUT, 8'h0B, 11'd0);
        send_request(CMD_PUT, 8'h09, 11'd0);
        send_request(CMD_READ, 8'h00, 11'd160);
        send_request(CMD_READ, 8'h00, 11'd1024);

        // random phases, each under its own colour
        phase_colour[0] = 8'hFF;
        phase_colour[1] = 8'h00;
        phase_colour[2] = t_attr'($urandom_range(0, 255));
        phase_colour[3] = t_attr'($urandom_range(0, 255));
        phase_colour[4] = 8'h80;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_colour(phase_colour[p]);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    // noise: any command, character and address
                    send_request(t_cmd'($urandom_range(0, 1)), t_char'($urandom_range(0, 255)),
                                 t_cell_addr'($urandom_range(0, 2047)));
                    sent++;
                end else if (pick < 45) begin
                    // print run, now and then long enough to wrap the line
                    run_len = ($urandom_range(0, 99) < 15) ? $urandom_range(70, 90)
                                                           : $urandom_range(1, 12);
                    repeat (run_len) begin
                        ch = t_char'($urandom_range(0, 255));
                        if (ch == NEWLINE_CODE) begin
                            ch = ~ch;
                        end
                        send_request(CMD_PUT, ch, t_cell_addr'($urandom_range(0, 2047)));
                    end
                    sent += run_len;
                end else if (pick < 70) begin
                    // newline burst
                    run_len = $urandom_range(1, 4);
                    repeat (run_len) begin
                        send_request(CMD_PUT, NEWLINE_CODE, t_cell_addr'($urandom_range(0, 2047)));
                    end
                    sent += run_len;
                end else begin
                    // read burst, weighted towards the bottom rows where the cursor lives
                    run_len = $urandom_range(1, 5);
                    repeat (run_len) begin
                        pick = $urandom_range(0, 99);
                        if (pick < 40) begin
                            addr = t_cell_addr'($urandom_range(LAST_BASE - COLUMNS, CELL_LAST));
                        end else if (pick < 60) begin
                            addr = t_cell_addr'($urandom_range(0, CELL_LAST));
                        end else begin
                            addr = t_cell_addr'($urandom_range(0, 2047));
                        end
                        send_request(CMD_READ, t_char'($urandom_range(0, 255)), addr);
                    end
                    sent += run_len;
                end
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
